// ----- hw/rtl/isl_pkg.sv -----
`timescale 1ns / 1ps

package isl_pkg;

  localparam int CMD_W      = 3;
  localparam int POS_W      = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int COUNT_W    = 5;
  localparam int STATUS_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd6;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

// ----- hw/rtl/isl_ctrl.sv -----
`timescale 1ns / 1ps

module isl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output isl_pkg::ctrl_t ctrl
);
  import isl_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic done_next;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.exec  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.exec  = 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state == S_EXEC);

endmodule

// ----- hw/rtl/isl_datapath.sv -----
`timescale 1ns / 1ps

module isl_datapath #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  isl_pkg::ctrl_t                  ctrl,
  input  logic [isl_pkg::CMD_W-1:0]       cmd,
  input  logic [isl_pkg::POS_W-1:0]       position,
  input  logic [isl_pkg::IN_DATA_W-1:0]   data_in,
  output logic [isl_pkg::OUT_DATA_W-1:0]  read_data,
  output logic [isl_pkg::COUNT_W-1:0]     element_count,
  output logic [isl_pkg::STATUS_W-1:0]    status
);
  import isl_pkg::*;

  localparam int IW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  // Row of cells, entry 0 is the front.
  logic [DATA_WIDTH-1:0] cells [CAPACITY];
  logic [CW-1:0]         count;

  // Latched transaction.
  logic [CMD_W-1:0]      cmd_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] word_q;

  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      eff_pos;
  logic                  is_put;
  logic                  is_take;
  logic                  do_put;
  logic                  do_take;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [STATUS_W-1:0]   st;
  logic [CW-1:0]         count_next;
  logic [63:0]           rd_wide;

  assign cnt_ext = CMP_W'(count);
  assign pos_ext = CMP_W'(pos_q);

  always_comb begin
    eff_pos = '0;
    is_put  = 1'b0;
    is_take = 1'b0;
    do_put  = 1'b0;
    do_take = 1'b0;
    rd_word = '0;
    st      = ST_IGNORED;
    unique case (cmd_q)
      CMD_PUSH_BACK: begin
        is_put  = 1'b1;
        eff_pos = cnt_ext;
      end
      CMD_PUSH_FRONT: begin
        is_put  = 1'b1;
      end
      CMD_POP_BACK: begin
        // Wraps to all ones on an empty list, which lands out of range.
        is_take = 1'b1;
        eff_pos = cnt_ext - CMP_W'(1);
      end
      CMD_POP_FRONT: begin
        is_take = 1'b1;
      end
      CMD_INSERT: begin
        is_put  = 1'b1;
        eff_pos = pos_ext;
      end
      CMD_REMOVE: begin
        is_take = 1'b1;
        eff_pos = pos_ext;
      end
      CMD_READ: begin
        if (pos_ext < cnt_ext) begin
          rd_word = cells[pos_ext[IW-1:0]];
          st      = ST_DONE;
        end else if (count != '0) begin
          rd_word = cells[0];
        end
      end
      default: begin
        st = ST_IGNORED;
      end
    endcase

    if (is_put) begin
      if (eff_pos > cnt_ext) begin
        st = ST_IGNORED;
      end else if (cnt_ext >= CMP_W'(CAPACITY)) begin
        st = ST_FULL;
      end else begin
        st     = ST_DONE;
        do_put = 1'b1;
      end
    end
    if (is_take) begin
      if (eff_pos >= cnt_ext) begin
        st = ST_IGNORED;
      end else begin
        st      = ST_DONE;
        do_take = 1'b1;
      end
    end
  end

  always_comb begin
    count_next = count;
    if (do_put) begin
      count_next = count + CW'(1);
    end else if (do_take) begin
      count_next = count - CW'(1);
    end
  end

  assign rd_wide = 64'(rd_word);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= cmd;
      pos_q  <= position;
      word_q <= DATA_WIDTH'(64'(data_in));
    end
  end

  // Shift the whole row in one step.
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_put) begin
          if (CMP_W'(i) == eff_pos) begin
            cells[i] <= word_q;
          end else if (CMP_W'(i) > eff_pos) begin
            cells[i] <= cells[(i == 0) ? 0 : i - 1];
          end
        end else if (do_take) begin
          if (CMP_W'(i) >= eff_pos && i < CAPACITY - 1) begin
            cells[i] <= cells[(i == CAPACITY - 1) ? i : i + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      read_data     <= rd_wide[OUT_DATA_W-1:0];
      element_count <= COUNT_W'(CMP_W'(count_next));
      status        <= st;
    end
  end

endmodule

// ----- hw/rtl/indexed_sequence_list_core.sv -----
`timescale 1ns / 1ps
// The accepting edge latches the transaction; the execute state then registers the result.
// A new transaction is accepted only while busy is low; busy is high for the execute cycle.
// The whole row of cells shifts in the execute cycle, so every command costs the same.
// The result shows for one cycle with done high; the receiver cannot stall.
// Reset (rst, synchronous): the list is empty and the controller idles.
module indexed_sequence_list_core #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [isl_pkg::CMD_W-1:0]       cmd,
  input  logic [isl_pkg::POS_W-1:0]       position,
  input  logic [isl_pkg::IN_DATA_W-1:0]   data_in,
  output logic                            done,
  output logic [isl_pkg::OUT_DATA_W-1:0]  read_data,
  output logic [isl_pkg::COUNT_W-1:0]     element_count,
  output logic [isl_pkg::STATUS_W-1:0]    status
);
  import isl_pkg::*;

  ctrl_t ctrl;

  isl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  isl_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cmd           (cmd),
    .position      (position),
    .data_in       (data_in),
    .read_data     (read_data),
    .element_count (element_count),
    .status        (status)
  );

endmodule

// ----- hw/rtl/isl_checker.sv -----
`timescale 1ns / 1ps

module isl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [isl_pkg::STATUS_W-1:0]  status
);
  import isl_pkg::*;

  // An accepted transaction raises busy, with done still low, in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not raise busy");

  // Every execute cycle ends in exactly one result.
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("execute cycle did not produce a result");

  // No result without a transaction before it.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    (!busy) |=> !done)
    else $error("result strobe without an executing transaction");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_DONE || status == ST_IGNORED || status == ST_FULL))
    else $error("undefined status code");

endmodule

bind indexed_sequence_list_core isl_checker u_isl_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status)
);

// ----- tb/indexed_sequence_list_core_tb.sv -----
`timescale 1ns / 1ps

module indexed_sequence_list_core_tb;
  import isl_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]     op;
    logic [POS_W-1:0]     pos;
    logic [IN_DATA_W-1:0] word;
  } list_cmd_t;

  typedef struct {
    logic [OUT_DATA_W-1:0] read_data;
    logic [COUNT_W-1:0]    element_count;
    logic [STATUS_W-1:0]   status;
  } list_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CMD_W-1:0]      cmd = '0;
  logic [POS_W-1:0]      position = '0;
  logic [IN_DATA_W-1:0]  data_in = '0;
  logic                  done;
  logic [OUT_DATA_W-1:0] read_data;
  logic [COUNT_W-1:0]    element_count;
  logic [STATUS_W-1:0]   status;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];
  int           error_count = 0;
  int           burst_left = 6;
  int           gap_left = 0;

  // Shadow copy of the list contents.
  logic [IN_DATA_W-1:0] shadow_words[LIST_DEPTH];
  int unsigned          shadow_len = 0;

  indexed_sequence_list_core #(
    .CAPACITY  (LIST_DEPTH),
    .DATA_WIDTH(IN_DATA_W)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .position     (position),
    .data_in      (data_in),
    .done         (done),
    .read_data    (read_data),
    .element_count(element_count),
    .status       (status)
  );

  always #2 clk = ~clk;

  function automatic logic [STATUS_W-1:0] shadow_insert(int unsigned p,
                                                         logic [IN_DATA_W-1:0] w);
    if (p > shadow_len) return ST_IGNORED;
    // Range check wins over the full check.
    if (shadow_len >= LIST_DEPTH) return ST_FULL;
    for (int unsigned i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[p] = w;
    shadow_len++;
    return ST_DONE;
  endfunction

  function automatic logic [STATUS_W-1:0] shadow_remove(int unsigned p);
    if (p >= shadow_len) return ST_IGNORED;
    for (int unsigned i = p; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
    shadow_len--;
    return ST_DONE;
  endfunction

  function automatic list_result_t predict_list_op(list_cmd_t c);
    list_result_t r;
    r.read_data = '0;
    case (c.op)
      CMD_PUSH_BACK:  r.status = shadow_insert(shadow_len, c.word);
      CMD_PUSH_FRONT: r.status = shadow_insert(0, c.word);
      CMD_POP_BACK:   r.status = (shadow_len == 0) ? ST_IGNORED : shadow_remove(shadow_len - 1);
      CMD_POP_FRONT:  r.status = shadow_remove(0);
      CMD_INSERT:     r.status = shadow_insert(c.pos, c.word);
      CMD_REMOVE:     r.status = shadow_remove(c.pos);
      CMD_READ: begin
        if (c.pos < shadow_len) begin
          r.read_data = shadow_words[c.pos];
          r.status    = ST_DONE;
        end else begin
          // Out of range answers with the front word, or zero when empty.
          r.read_data = (shadow_len > 0) ? shadow_words[0] : '0;
          r.status    = ST_IGNORED;
        end
      end
      default:        r.status = ST_IGNORED;
    endcase
    r.element_count = COUNT_W'(shadow_len);
    return r;
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                           logic [IN_DATA_W-1:0] word);
    list_cmd_t c;
    c.op   = op;
    c.pos  = pos;
    c.word = word;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  function automatic logic [IN_DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] random_op(bit grow);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 30) return CMD_PUSH_BACK;
      if (r < 50) return CMD_PUSH_FRONT;
      if (r < 70) return CMD_INSERT;
      if (r < 80) return CMD_READ;
      if (r < 86) return CMD_POP_BACK;
      if (r < 92) return CMD_POP_FRONT;
      if (r < 98) return CMD_REMOVE;
    end else begin
      if (r < 8)  return CMD_PUSH_BACK;
      if (r < 14) return CMD_PUSH_FRONT;
      if (r < 22) return CMD_INSERT;
      if (r < 37) return CMD_READ;
      if (r < 57) return CMD_POP_BACK;
      if (r < 72) return CMD_POP_FRONT;
      if (r < 98) return CMD_REMOVE;
    end
    return CMD_UNUSED;
  endfunction

  // Driver: hold a transaction until busy is low, then advance or idle.
  always @(posedge clk) begin
    list_cmd_t next_cmd;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        next_cmd.op   = cmd;
        next_cmd.pos  = position;
        next_cmd.word = data_in;
        expected_results.insert(expected_results.size(), predict_list_op(next_cmd));
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      if (start && busy) begin
        // hold the current transaction
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_cmd = pending_cmds[0];
        pending_cmds.delete(0);
        start    <= 1'b1;
        cmd      <= next_cmd.op;
        position <= next_cmd.pos;
        data_in  <= next_cmd.word;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done strobe must match the oldest expectation.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result read_data=%h element_count=%0d status=%0d",
                 $time, read_data, element_count, status);
        error_count++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (read_data !== want.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, want.read_data, read_data);
          error_count++;
        end
        if (element_count !== want.element_count) begin
          $display("%0t: element_count expected %0d actual %0d",
                   $time, want.element_count, element_count);
          error_count++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          error_count++;
        end
      end
    end
  end

  initial begin
    // Empty-list corner cases.
    queue_cmd(CMD_READ, 5'd0, 32'h1234_5678);
    queue_cmd(CMD_READ, 5'd31, '0);
    queue_cmd(CMD_POP_BACK, 5'd0, '0);
    queue_cmd(CMD_POP_FRONT, 5'd0, '0);
    queue_cmd(CMD_REMOVE, 5'd0, '0);
    queue_cmd(CMD_INSERT, 5'd1, 32'hDEAD_BEEF);
    queue_cmd(CMD_UNUSED, 5'd31, '1);
    // Build a short list and walk it.
    queue_cmd(CMD_PUSH_BACK, 5'd0, '1);
    queue_cmd(CMD_PUSH_FRONT, 5'd0, '0);
    queue_cmd(CMD_INSERT, 5'd1, 32'hA5A5_A5A5);
    queue_cmd(CMD_INSERT, 5'd3, 32'h5A5A_5A5A);
    queue_cmd(CMD_INSERT, 5'd5, 32'h0BAD_F00D);
    for (int i = 0; i < 4; i++) queue_cmd(CMD_READ, POS_W'(i), '0);
    queue_cmd(CMD_READ, 5'd4, '0);
    queue_cmd(CMD_READ, 5'd31, '0);
    queue_cmd(CMD_REMOVE, 5'd4, '0);
    queue_cmd(CMD_REMOVE, 5'd1, '0);
    queue_cmd(CMD_POP_BACK, 5'd0, '0);
    queue_cmd(CMD_POP_FRONT, 5'd0, '0);
    queue_cmd(CMD_INSERT, 5'd16, 32'hFFFF_0000);
    queue_cmd(CMD_READ, 5'd0, '0);

    // Alternate growing and shrinking phases so the list fills and empties.
    for (int phase = 0; phase < 10; phase++) begin
      repeat (40) begin
        queue_cmd(random_op(phase % 2 == 0),
                  ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(0, 31))
                                              : POS_W'($urandom_range(0, 16)),
                  random_word());
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/isl_pkg.sv
hw/rtl/isl_ctrl.sv
hw/rtl/isl_datapath.sv
hw/rtl/indexed_sequence_list_core.sv
hw/rtl/isl_checker.sv
tb/indexed_sequence_list_core_tb.sv
